### hw/rtl/ddfg_pkg.sv
// Package for the decimal display frame generator.
// Field widths, blank code, divide-by-ten constants and the cell status type.
// No dependencies.
package ddfg_pkg;

   // beat field widths
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int CODE_W  = 4;

   // digit count range and the width of the frame counter that covers it
   localparam int MAX_DIGITS        = 8;
   localparam int DIGIT_COUNT_DEF   = 8;
   localparam int CNT_W             = 3;

   // code shown for a blanked leading zero
   localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

   // x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   // status one cell hands to the frame output mux
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } cell_out_type;

endpackage

### hw/rtl/decimal_display_frame_generator_top.sv
// Top level of the decimal display frame generator: a chain of digit cells
// and the frame output mux. Depends on ddfg_pkg and ddfg_cell.
//
// A value is taken when start is high and busy is low. It then travels down a
// chain of DIGIT_COUNT cells, one cell per cycle, each peeling off one decimal
// digit, so frames leave on rsp_strobe in consecutive cycles: position 1 in
// the cycle after the value is taken, position DIGIT_COUNT last, flagged by
// rsp_last_frame. The strobe cannot be held off; each frame is on the ports
// for exactly one cycle. busy stays high after a value is taken until the
// spacing counter runs down, so a new value can be taken while
// the previous one is still in the chain; the spacing is set by the single
// frame output port. Leading zeros show as code 15; decimal digits above
// position DIGIT_COUNT are dropped.
module decimal_display_frame_generator_top #(
   parameter int DIGIT_COUNT = ddfg_pkg::DIGIT_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ddfg_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_strobe,
   output logic [ddfg_pkg::POS_W-1:0]   rsp_digit_position,
   output logic [ddfg_pkg::CODE_W-1:0]  rsp_digit_code,
   output logic                         rsp_last_frame
);
   import ddfg_pkg::*;

   localparam int NCELL = (DIGIT_COUNT < 1) ? 1 :
                          ((DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT);

   logic                 accept;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [VALUE_W-1:0]   rest [NCELL];
   cell_out_type         stat [NCELL];
   logic [NCELL-1:0]     valid_vec;

   assign accept = start && !busy;
   assign busy   = (cnt_ff != '0);

   // spacing counter: holds the input off until the chain has room
   always_comb begin
      if (accept) begin
         cnt_in = CNT_W'(NCELL - 1);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // digit cell chain
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      if (k == 0) begin : g_head
         ddfg_cell #(.FIRST(1'b1)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .in_valid (accept),
            .in_rest  (req_value),
            .out_rest (rest[k]),
            .out_stat (stat[k])
         );
      end else begin : g_body
         ddfg_cell #(.FIRST(1'b0)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .in_valid (stat[k-1].valid),
            .in_rest  (rest[k-1]),
            .out_rest (rest[k]),
            .out_stat (stat[k])
         );
      end
      assign valid_vec[k] = stat[k].valid;
   end

   // frame mux: at most one cell holds a frame in any cycle
   always_comb begin
      rsp_digit_position = '0;
      rsp_digit_code     = '0;
      for (int k = 0; k < NCELL; k++) begin
         if (stat[k].valid) begin
            rsp_digit_position = rsp_digit_position | POS_W'(k + 1);
            rsp_digit_code     = rsp_digit_code | stat[k].code;
         end
      end
   end

   assign rsp_strobe     = |valid_vec;
   assign rsp_last_frame = stat[NCELL-1].valid;

`ifndef SYNTHESIS
   // chain spacing keeps frames from colliding at the mux
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_vec))
      else $error("more than one cell holds a frame");

   // the first frame follows the taken value directly
   a_first_frame: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe && (rsp_digit_position == POS_W'(1))))
      else $error("position 1 frame missing after accept");

   // position 1 is never blanked
   a_no_blank_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_digit_position == POS_W'(1))) |-> (rsp_digit_code <= 4'd9))
      else $error("position 1 frame is blank or out of range");

   // no new value while frames of the last one are still starting
   a_busy_span: assert property (@(posedge clock) disable iff (reset)
      (accept && (NCELL > 1)) |=> busy)
      else $error("busy not raised after accept");
`endif

endmodule

### hw/rtl/ddfg_cell.sv
// One digit cell: splits the incoming remainder into a decimal digit and a
// quotient for the next cell. Depends on ddfg_pkg.
module ddfg_cell #(
   parameter bit FIRST = 1'b0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ddfg_pkg::VALUE_W-1:0] in_rest,
   output logic [ddfg_pkg::VALUE_W-1:0] out_rest,
   output ddfg_pkg::cell_out_type       out_stat
);
   import ddfg_pkg::*;

   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W-1:0]   quot_in;
   logic [VALUE_W-1:0]   rem;
   logic [CODE_W-1:0]    code_in;
   logic [VALUE_W-1:0]   quot_ff;
   logic [CODE_W-1:0]    code_ff;
   logic                 valid_ff;

   // divide by ten through the reciprocal, remainder by shift-add
   assign prod    = in_rest * RECIP_TEN;
   assign quot_in = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
   assign rem     = in_rest - ((quot_in << 3) + (quot_in << 1));

   // leading zero blanking; the lowest position always shows its digit
   always_comb begin
      if (!FIRST && (in_rest == '0)) begin
         code_in = BLANK_CODE;
      end else begin
         code_in = rem[CODE_W-1:0];
      end
   end

   // valid travels with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid) begin
         quot_ff <= quot_in;
         code_ff <= code_in;
      end
   end

   assign out_rest       = quot_ff;
   assign out_stat.valid = valid_ff;
   assign out_stat.code  = code_ff;

endmodule
